FILE: sv/cda_pkg.sv
package cda_pkg;

   // Geometry of the bank table and the streams.
   localparam int unsigned BANKS       = 64;
   localparam int unsigned BANK_W      = 6;
   localparam int unsigned COLUMN_W    = 16;
   localparam int unsigned COUNT_W     = 21;
   localparam int unsigned OFFSET_W    = 32;
   localparam int unsigned SLOT_W      = 16;

   // Burst size in bytes; must be a power of two.
   localparam int unsigned BURST_SIZE  = 32;

   // Width of an end computation: offset plus payload plus padding.
   localparam int unsigned SUM_W       = OFFSET_W + 2;

   // One bank entry: padded ends of both streams and the next slot.
   typedef struct packed {
      logic [OFFSET_W-1:0] value_tail;
      logic [OFFSET_W-1:0] index_tail;
      logic [SLOT_W-1:0]   next_slot;
   } entry_type;

   // Sequencer states.
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_UPDATE
   } state_type;

endpackage

FILE: sv/cda_bank_ram.sv
module cda_bank_ram (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [cda_pkg::BANK_W-1:0]       rd_addr,
   output cda_pkg::entry_type               rd_data,
   input  logic                             wr_en,
   input  logic [cda_pkg::BANK_W-1:0]       wr_addr,
   input  cda_pkg::entry_type               wr_data
);

   cda_pkg::entry_type             mem_ff [cda_pkg::BANKS];
   logic [cda_pkg::BANKS-1:0]      vld_ff;
   cda_pkg::entry_type             rd_raw_ff;
   logic                           rd_vld_ff;

   // Entry storage, written without reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem_ff[rd_addr];
      end
   end

   // Valid bits: an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

FILE: sv/cda_alloc_calc.sv
module cda_alloc_calc (
   input  cda_pkg::entry_type               cur,
   input  logic [cda_pkg::COUNT_W-1:0]      count,
   output cda_pkg::entry_type               nxt,
   output logic                             overflow
);

   localparam logic [cda_pkg::SUM_W-1:0] PAD = cda_pkg::SUM_W'(cda_pkg::BURST_SIZE - 1);

   logic [cda_pkg::SUM_W-1:0] value_sum;
   logic [cda_pkg::SUM_W-1:0] index_sum;
   logic [cda_pkg::SUM_W-1:0] value_pad;
   logic [cda_pkg::SUM_W-1:0] index_pad;

   // Stored ends are always burst aligned, so they serve as the offsets.
   // New ends: offset plus payload (2 or 4 bytes per element), padded up.
   always_comb begin
      value_sum = cda_pkg::SUM_W'(cur.value_tail) + cda_pkg::SUM_W'({count, 1'b0}) + PAD;
      index_sum = cda_pkg::SUM_W'(cur.index_tail) + cda_pkg::SUM_W'({count, 2'b00}) + PAD;
      value_pad = value_sum & ~PAD;
      index_pad = index_sum & ~PAD;
      overflow  = (|value_pad[cda_pkg::SUM_W-1:cda_pkg::OFFSET_W])
                | (|index_pad[cda_pkg::SUM_W-1:cda_pkg::OFFSET_W]);
      nxt.value_tail = value_pad[cda_pkg::OFFSET_W-1:0];
      nxt.index_tail = index_pad[cda_pkg::OFFSET_W-1:0];
      nxt.next_slot  = cur.next_slot + cda_pkg::SLOT_W'(1);
   end

endmodule

FILE: sv/csc_column_descriptor_allocator_unit.sv
// Column descriptor allocator: each accepted word with a nonzero count yields
// one descriptor word carrying the burst-aligned value and row-index offsets of
// its bank, the bank's slot, and the echoed count, column and bank; a column
// whose padded end would pass 32-bit byte space yields a word with overflow set
// and zero offsets and slot, and leaves the bank untouched. Zero-count words are
// taken and produce nothing. Every other word first reads the bank entry from
// the bank table, then computes the new entry and writes it back. A finished
// descriptor waits in the output register while the next word is accepted;
// only the write-back stalls on a full output.
module csc_column_descriptor_allocator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [cda_pkg::COLUMN_W-1:0]         req_column,
   input  logic [cda_pkg::COUNT_W-1:0]          req_nnz_count,
   input  logic [cda_pkg::BANK_W-1:0]           req_bank,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cda_pkg::OFFSET_W-1:0]         rsp_value_offset,
   output logic [cda_pkg::OFFSET_W-1:0]         rsp_index_offset,
   output logic [cda_pkg::COUNT_W-1:0]          rsp_element_count,
   output logic [cda_pkg::SLOT_W-1:0]           rsp_slot,
   output logic [cda_pkg::COLUMN_W-1:0]         rsp_source_column,
   output logic [cda_pkg::BANK_W-1:0]           rsp_owner_bank,
   output logic                                 rsp_overflow
);

   cda_pkg::state_type               state_ff, state_in;
   logic [cda_pkg::COLUMN_W-1:0]     column_ff;
   logic [cda_pkg::COUNT_W-1:0]      count_ff;
   logic [cda_pkg::BANK_W-1:0]       bank_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cda_pkg::OFFSET_W-1:0]     voff_ff;
   logic [cda_pkg::OFFSET_W-1:0]     ioff_ff;
   logic [cda_pkg::COUNT_W-1:0]      ecount_ff;
   logic [cda_pkg::SLOT_W-1:0]       slot_ff;
   logic [cda_pkg::COLUMN_W-1:0]     scol_ff;
   logic [cda_pkg::BANK_W-1:0]       obank_ff;
   logic                             ovf_ff;

   logic                             accept;
   logic                             start;
   logic                             load;
   cda_pkg::entry_type               cur_entry;
   cda_pkg::entry_type               nxt_entry;
   logic                             calc_ovf;

   assign accept = req_valid & req_ready;
   assign start  = accept & (req_nnz_count != '0);

   // Bank table.
   cda_bank_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (start),
      .rd_addr (req_bank),
      .rd_data (cur_entry),
      .wr_en   (load & ~calc_ovf),
      .wr_addr (bank_ff),
      .wr_data (nxt_entry)
   );

   // Offset and slot arithmetic.
   cda_alloc_calc u_calc (
      .cur      (cur_entry),
      .count    (count_ff),
      .nxt      (nxt_entry),
      .overflow (calc_ovf)
   );

   // Sequencer: next state and handshake.
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      load         = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         cda_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (start) begin
               state_in = cda_pkg::ST_UPDATE;
            end
         end
         cda_pkg::ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cda_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured input word.
   always_ff @(posedge clock) begin
      if (start) begin
         column_ff <= req_column;
         count_ff  <= req_nnz_count;
         bank_ff   <= req_bank;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (load) begin
         voff_ff   <= calc_ovf ? '0 : cur_entry.value_tail;
         ioff_ff   <= calc_ovf ? '0 : cur_entry.index_tail;
         slot_ff   <= calc_ovf ? '0 : cur_entry.next_slot;
         ecount_ff <= count_ff;
         scol_ff   <= column_ff;
         obank_ff  <= bank_ff;
         ovf_ff    <= calc_ovf;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_offset  = voff_ff;
   assign rsp_index_offset  = ioff_ff;
   assign rsp_element_count = ecount_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_source_column = scol_ff;
   assign rsp_owner_bank    = obank_ff;
   assign rsp_overflow      = ovf_ff;

endmodule
